// ----- design/tksk_pkg.sv -----
package tksk_pkg;

  localparam int unsigned ID_W    = 24;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  // One kept pair as held in a chain cell.
  typedef struct packed {
    logic                      valid;
    logic [ID_W-1:0]           id;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  // Controls broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the offered pair at its sorted position
    logic grow;    // the store gains a pair (not a replacement)
    logic pop;     // shift every entry one place toward the head
  } ctl_t;

  localparam entry_t EMPTY_ENTRY = '{valid: 1'b0, id: '0, score: '0};

endpackage

// ----- design/tksk_cell.sv -----
module tksk_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  tksk_pkg::ctl_t                      ctl,
  input  logic [tksk_pkg::ID_W-1:0]           new_id,
  input  logic signed [tksk_pkg::SCORE_W-1:0] new_score,
  input  tksk_pkg::entry_t                    prev_entry,
  input  logic                                prev_ge,
  input  tksk_pkg::entry_t                    next_entry,
  output tksk_pkg::entry_t                    entry,
  output logic                                ge
);

  tksk_pkg::entry_t entry_next;

  // Held pair ranks at or above the offer, so the offer goes below it.
  assign ge = entry.valid && (entry.score >= new_score);

  always_comb begin
    entry_next = entry;
    if (ctl.pop) begin
      entry_next = next_entry;
    end else if (ctl.insert && !ge) begin
      if (prev_ge) begin
        entry_next.id    = new_id;
        entry_next.score = new_score;
        entry_next.valid = ctl.grow ? 1'b1 : entry.valid;
      end else begin
        entry_next.id    = prev_entry.id;
        entry_next.score = prev_entry.score;
        entry_next.valid = ctl.grow ? prev_entry.valid : entry.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry.id    <= entry_next.id;
    entry.score <= entry_next.score;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

// ----- design/top_k_score_keeper_unit.sv -----
// Top-K score keeper: holds the best (item, score) pairs of an offered stream
// in a chain of cells sorted by descending score, ties in arrival order.
//
// Input channel (in_valid / in_stall): op 0 offers item_id with score, op 1
// flushes. For an offer, all cells compare against the broadcast
// score at once and the chain shifts to open a slot, so offers can be taken
// back to back. A zero score is dropped; when the store is full the offer
// replaces the lowest pair only if its score is strictly greater.
// A flush drains the chain one pair per cycle, while the output is not stalled,
// from its head cell into the output register, and holds in_stall until the head
// cell is empty. The flush transfer sets draining, and the first pair then moves
// into the output register; last marks the final pair; an empty store gives nothing.
// Output channel (out_valid / out_stall): while the receiver stalls, the
// output register holds and the drain waits, so no pair is lost.
// cfg_wr_en / cfg_wr_data write the keep limit (0 acts as 1, above MAX_KEEP
// acts as MAX_KEEP); write it only while idle.
// Reset (rst, synchronous) empties the store, sets the limit to 10 and
// clears out_valid.
module top_k_score_keeper_unit #(
  parameter int unsigned MAX_KEEP = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tksk_pkg::LIMIT_W-1:0]        cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic [tksk_pkg::ID_W-1:0]           item_id,
  input  logic signed [tksk_pkg::SCORE_W-1:0] score,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tksk_pkg::ID_W-1:0]           out_item,
  output logic signed [tksk_pkg::SCORE_W-1:0] out_score,
  output logic                                last
);

  localparam int unsigned CW = $clog2(MAX_KEEP + 1);
  localparam int unsigned LW = (CW > tksk_pkg::LIMIT_W) ? CW : tksk_pkg::LIMIT_W;

  logic [tksk_pkg::LIMIT_W-1:0] keep_limit;
  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic                         draining;
  logic [LW-1:0]                limit_ext;
  logic [LW-1:0]                limit_eff;
  logic                         full;
  logic                         beats_last;
  logic                         in_xfer;
  logic                         out_free;
  tksk_pkg::ctl_t               ctl;

  tksk_pkg::entry_t cell_q [MAX_KEEP];
  logic             cell_ge[MAX_KEEP];

  assign in_stall = draining;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign limit_ext = LW'(keep_limit);
  always_comb begin
    if (limit_ext == '0) begin
      limit_eff = LW'(1);
    end else if (limit_ext > LW'(MAX_KEEP)) begin
      limit_eff = LW'(MAX_KEEP);
    end else begin
      limit_eff = limit_ext;
    end
  end

  assign full = LW'(count) >= limit_eff;

  // Offer beats the lowest kept pair: the last valid cell does not rank at or above it.
  always_comb begin
    beats_last = 1'b0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (cell_q[i].valid && !cell_ge[i]) begin
        if (i == MAX_KEEP - 1) begin
          beats_last = 1'b1;
        end else if (!cell_q[(i + 1) % MAX_KEEP].valid) begin
          beats_last = 1'b1;
        end
      end
    end
  end

  always_comb begin
    ctl.grow   = !full;
    ctl.insert = in_xfer && (op == tksk_pkg::OP_OFFER) && (score != '0)
                 && (!full || beats_last);
    ctl.pop    = draining && cell_q[0].valid && out_free;
  end

  always_comb begin
    count_next = count;
    if (ctl.pop) begin
      count_next = count - CW'(1);
    end else if (ctl.insert && ctl.grow) begin
      count_next = count + CW'(1);
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_KEEP; g++) begin : g_cell
      tksk_pkg::entry_t prev_entry;
      tksk_pkg::entry_t next_entry;
      logic             prev_ge;

      if (g == 0) begin : g_head
        assign prev_entry = tksk_pkg::EMPTY_ENTRY;
        assign prev_ge    = 1'b1;
      end else begin : g_body
        assign prev_entry = cell_q[g-1];
        assign prev_ge    = cell_ge[g-1];
      end

      if (g == MAX_KEEP - 1) begin : g_tail
        assign next_entry = tksk_pkg::EMPTY_ENTRY;
      end else begin : g_mid
        assign next_entry = cell_q[g+1];
      end

      tksk_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .new_id     (item_id),
        .new_score  (score),
        .prev_entry (prev_entry),
        .prev_ge    (prev_ge),
        .next_entry (next_entry),
        .entry      (cell_q[g]),
        .ge         (cell_ge[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_limit <= tksk_pkg::LIMIT_RESET;
      count      <= '0;
      draining   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        keep_limit <= cfg_wr_data;
      end
      count <= count_next;
      if (in_xfer && (op == tksk_pkg::OP_FLUSH)) begin
        draining <= 1'b1;
      end else if (draining && !cell_q[0].valid) begin
        draining <= 1'b0;
      end
      if (ctl.pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Head cell moves into the output register on each pop.
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      out_item  <= cell_q[0].id;
      out_score <= cell_q[0].score;
      last      <= (MAX_KEEP == 1) ? 1'b1 : !cell_q[(MAX_KEEP > 1) ? 1 : 0].valid;
    end
  end

endmodule

// ----- design/tksk_checker.sv -----
module tksk_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                op,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [tksk_pkg::ID_W-1:0]           out_item,
  input logic signed [tksk_pkg::SCORE_W-1:0] out_score,
  input logic                                last
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item) && $stable(out_score)
                               && $stable(last))
    else $error("output changed while stalled");

  // Results only come out of a drain.
  a_out_from_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared outside a flush");

  // A flush transfer blocks new items while the store drains.
  a_flush_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (op == tksk_pkg::OP_FLUSH) |=> in_stall)
    else $error("flush did not start a drain");

  // More pairs follow a transfer that is not the last, so the drain goes on.
  a_drain_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> in_stall)
    else $error("drain ended before the last pair");

endmodule

bind top_k_score_keeper_unit tksk_checker u_tksk_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .op        (op),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item),
  .out_score (out_score),
  .last      (last)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned KEEP_DEPTH     = 16;
  localparam int unsigned RANDOM_ITEMS   = 72;
  localparam int unsigned LONG_HOLD      = 160;
  localparam int unsigned DRAIN_SETTLE   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef logic [tksk_pkg::ID_W-1:0]           id_t;
  typedef logic signed [tksk_pkg::SCORE_W-1:0] score_t;
  typedef logic [tksk_pkg::LIMIT_W-1:0]        limit_t;

  typedef struct {
    id_t    item;
    score_t value;
    logic   is_last;
  } ranked_pair_t;

  localparam score_t SCORE_MAX = 32'sh7FFF_FFFF;
  localparam score_t SCORE_MIN = 32'sh8000_0000;
  localparam score_t ONE_Q16   = 32'sh0001_0000;

  class ranking_board;
    id_t          kept_id[KEEP_DEPTH];
    score_t       kept_score[KEEP_DEPTH];
    int unsigned  kept_n;
    limit_t       limit_reg;
    ranked_pair_t due_pairs[$];
    int unsigned  mismatches;
    int unsigned  pairs_checked;

    function new();
      kept_n        = 0;
      limit_reg     = tksk_pkg::LIMIT_RESET;
      mismatches    = 0;
      pairs_checked = 0;
    endfunction

    function void set_limit(limit_t v);
      limit_reg = v;
    endfunction

    function int unsigned room();
      if (limit_reg == 0) return 1;
      if (limit_reg > KEEP_DEPTH) return KEEP_DEPTH;
      return limit_reg;
    endfunction

    // Insert behind every pair of equal or higher score, so ties keep arrival order.
    function void place(id_t id, score_t sc);
      int unsigned pos;
      pos = 0;
      while (pos < kept_n && kept_score[pos] >= sc) pos++;
      for (int unsigned i = kept_n; i > pos; i--) begin
        kept_id[i]    = kept_id[i-1];
        kept_score[i] = kept_score[i-1];
      end
      kept_id[pos]    = id;
      kept_score[pos] = sc;
      kept_n++;
    endfunction

    function void note_request(tksk_pkg::op_t kind, id_t id, score_t sc);
      if (kind == tksk_pkg::OP_OFFER) begin
        if (sc == 0) return;
        if (kept_n < room()) begin
          place(id, sc);
        end else if (kept_n > 0 && sc > kept_score[kept_n-1]) begin
          // drop the latest-arrived of the lowest pairs
          kept_n--;
          place(id, sc);
        end
      end else begin
        for (int unsigned k = 0; k < kept_n; k++)
          due_pairs.push_back('{kept_id[k], kept_score[k], (k + 1 == kept_n)});
        kept_n = 0;
      end
    endfunction

    function void check_pair(id_t id, score_t sc, logic is_last);
      ranked_pair_t want;
      pairs_checked++;
      if (due_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected pair: item %h score %h last %b", id, sc, is_last);
        return;
      end
      want = due_pairs.pop_front();
      if (id !== want.item || sc !== want.value || is_last !== want.is_last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("pair mismatch: item %h/%h score %h/%h last %b/%b (expected/actual)",
                   want.item, id, want.value, sc, want.is_last, is_last);
      end
    endfunction
  endclass

  logic   clk;
  logic   rst         = 1'b1;
  logic   cfg_wr_en   = 1'b0;
  limit_t cfg_wr_data = '0;
  logic   in_valid    = 1'b0;
  logic   in_stall;
  logic   op          = 1'b0;
  id_t    item_id     = '0;
  score_t score       = '0;
  logic   out_valid;
  logic   out_stall   = 1'b0;
  id_t    out_item;
  score_t out_score;
  logic   last;

  ranking_board board = new();

  bit          sender_calm   = 1'b0;
  int unsigned hold_ticket   = 0;
  int unsigned requests_sent = 0;
  int unsigned flushes_sent  = 0;
  int unsigned limits_used   = 0;

  top_k_score_keeper_unit #(.MAX_KEEP(KEEP_DEPTH)) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .item_id     (item_id),
    .score       (score),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .out_score   (out_score),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic score_t pick_score();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 2) return '0;
    if (roll < 4) begin
      case ($urandom_range(0, 3))
        0:       return SCORE_MAX;
        1:       return SCORE_MIN;
        2:       return 32'sd1;
        default: return -32'sd1;
      endcase
    end
    // narrow band of whole values so ties and replacements are frequent
    if (roll < 12) return score_t'((int'($urandom_range(0, 16)) - 8) * 65536);
    return score_t'($urandom);
  endfunction

  task automatic send_request(input tksk_pkg::op_t kind, input id_t id, input score_t sc);
    int unsigned gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    item_id  <= id;
    score    <= sc;
    do @(posedge clk); while (in_stall);
    board.note_request(kind, id, sc);
    requests_sent++;
    if (kind == tksk_pkg::OP_FLUSH) flushes_sent++;
  endtask

  // Hold off until every pair has arrived and the block has gone quiet.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.due_pairs.size() != 0);
    repeat (DRAIN_SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input limit_t v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_limit(v);
    limits_used++;
  endtask

  initial begin : stimulus
    int unsigned random_done;
    int unsigned phase;
    int unsigned phase_len;
    limit_t      lim;
    score_t      sc;
    random_done = 0;
    phase       = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset limit of 10: empty flush, extreme fields, dropped zero, a tie
    send_request(tksk_pkg::OP_FLUSH, 24'hFF_FFFF, score_t'(32'hFFFF_FFFF));
    send_request(tksk_pkg::OP_OFFER, 24'h00_0000, SCORE_MAX);
    send_request(tksk_pkg::OP_OFFER, 24'hFF_FFFF, SCORE_MIN);
    send_request(tksk_pkg::OP_OFFER, 24'h00_0123, '0);
    send_request(tksk_pkg::OP_OFFER, 24'hAB_CDEF, -32'sd1);
    send_request(tksk_pkg::OP_OFFER, 24'h00_0001, 32'sd1);
    send_request(tksk_pkg::OP_OFFER, 24'h00_0005, ONE_Q16);
    send_request(tksk_pkg::OP_OFFER, 24'h00_0006, ONE_Q16);
    send_request(tksk_pkg::OP_FLUSH, '0, '0);

    // full store: the newest of the tied lowest pairs goes, equal offers bounce
    write_limit(5'd3);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00A1, 32'sh0005_0000);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00A2, 32'sh0005_0000);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00A3, 32'sh0005_0000);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00A4, 32'sh0006_0000);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00A5, 32'sh0005_0000);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00A6, 32'sh0004_0000);
    send_request(tksk_pkg::OP_FLUSH, 24'h12_3456, 32'sh0BAD_0000);

    // limit 0 behaves as 1
    write_limit(5'd0);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00B1, 32'shFFFB_0000);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00B2, 32'shFFF9_0000);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00B3, 32'shFFFD_0000);
    send_request(tksk_pkg::OP_FLUSH, '0, '0);

    // lower the limit under the count: kept pairs stay, offers only replace
    write_limit(5'd16);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00C1, 32'sh0002_0000);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00C2, 32'sh0004_0000);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00C3, 32'sh0003_0000);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00C4, 32'sh0003_0000);
    write_limit(5'd2);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00C5, 32'sh0003_8000);
    send_request(tksk_pkg::OP_OFFER, 24'h00_00C6, 32'sh0003_0000);
    send_request(tksk_pkg::OP_FLUSH, '0, '0);

    while (random_done < RANDOM_ITEMS) begin
      case (phase % 6)
        0:       lim = 5'd31;
        1:       lim = 5'd1;
        2:       lim = 5'd16;
        3:       lim = 5'd0;
        4:       lim = limit_t'($urandom_range(17, 30));
        default: lim = limit_t'($urandom_range(2, 15));
      endcase
      write_limit(lim);
      sender_calm = (phase % 3 == 2);
      phase_len = $urandom_range(12, 26);
      for (int unsigned n = 0; n < phase_len; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(tksk_pkg::OP_FLUSH, id_t'($urandom), score_t'($urandom));
          random_done++;
        end else begin
          sc = pick_score();
          send_request(tksk_pkg::OP_OFFER, id_t'($urandom), sc);
          if (sc != 0) random_done++;
        end
      end
      // stall the receiver across this flush; later offers back up behind it
      if (phase == 2) hold_ticket <= hold_ticket + 1;
      send_request(tksk_pkg::OP_FLUSH, id_t'($urandom), score_t'($urandom));
      random_done++;
      if (phase == 2) begin
        repeat (8) send_request(tksk_pkg::OP_OFFER, id_t'($urandom), pick_score());
        send_request(tksk_pkg::OP_FLUSH, '0, '0);
      end
      phase++;
    end

    wait_drained();
    $display("covered %0d requests, %0d of them flushes, across %0d keep-limit writes",
             requests_sent, flushes_sent, limits_used);
    $display("%0d pairs checked, %0d mismatches", board.pairs_checked, board.mismatches);
    if (board.mismatches == 0 && board.due_pairs.size() == 0)
      $display("PASS top_k_score_keeper_unit");
    else
      $display("FAIL top_k_score_keeper_unit");
    $finish;
  end

  initial begin : receiver
    int unsigned stall_left;
    int unsigned open_left;
    int unsigned hold_seen;
    stall_left = 0;
    open_left  = 0;
    hold_seen  = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) board.check_pair(out_item, out_score, last);
      if (hold_ticket != hold_seen) begin
        hold_seen  = hold_ticket;
        stall_left = LONG_HOLD;
        open_left  = 0;
      end
      if (stall_left == 0 && open_left == 0) begin
        stall_left = pick_gap();
        open_left  = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        open_left--;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer in %0d cycles", quiet_cycles);
        $display("FAIL top_k_score_keeper_unit");
        $finish;
      end
    end
  end

endmodule
